/* hdl/xor_parity_repair_encoder_unit_assert.svh */
// Assertion macros used by the port checker of the XOR parity repair encoder.
`ifndef XOR_PARITY_REPAIR_ENCODER_UNIT_ASSERT_SVH
`define XOR_PARITY_REPAIR_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define XPRE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xpre port check failed");

// Next-cycle implication, ignored while reset is high.
`define XPRE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xpre port check failed");

// Same-cycle implication that is also checked around reset.
`define XPRE_ASSERT_ALW(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("xpre port check failed");

`endif

/* hdl/xpre_pkg.sv */
// Types, constants and helpers shared by the XOR parity repair encoder.
package xpre_pkg;

  localparam int PAYLOAD_MAX = 2048;
  localparam int GROUP_MAX   = 16;

  localparam int PAY_AW   = $clog2(PAYLOAD_MAX);
  localparam int GRP_AW   = $clog2(GROUP_MAX);
  localparam int LANES    = 8;
  localparam int LANE_AW  = $clog2(LANES);
  localparam int ROWS     = PAYLOAD_MAX / LANES;
  localparam int ROW_AW   = PAY_AW - LANE_AW;
  localparam int ROW_BITS = 8 * LANES;

  localparam int IDX_W      = 12;
  localparam int CNT_W      = 5;
  localparam int BODY_FIXED = 12;
  localparam int IN_TDATA_W = 128;

  localparam logic [63:0]      HDR_INIT      = 64'(1 << 6) << 56;
  localparam logic [CNT_W-1:0] GROUP_SIZE_RST = CNT_W'(4);

  typedef enum logic [1:0] {
    FUNC_HEADER  = 2'd0,
    FUNC_PAYLOAD = 2'd1,
    FUNC_EOP     = 2'd2,
    FUNC_READ    = 2'd3
  } func_t;

  // Input tdata layout, last member in the lowest bits.
  typedef struct packed {
    logic [1:0]       fill;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] byte_index;
    logic [11:0]      payload_length;
    logic [31:0]      ssrc;
    logic [15:0]      seq_number;
    logic [31:0]      timestamp;
    logic [6:0]       payload_type;
    logic             marker_bit;
    logic [3:0]       csrc_count;
    logic             ext_bit;
    logic             pad_bit;
  } item_t;

  typedef struct packed {
    logic                en;
    logic [ROW_AW-1:0]   row;
    logic [ROW_BITS-1:0] data;
  } xpre_wr_t;

  // Group size as used: zero acts as one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_group(input logic [CNT_W-1:0] g);
    logic [CNT_W-1:0] r;
    r = g;
    if (g == '0) r = CNT_W'(1);
    if (int'(g) > GROUP_MAX) r = CNT_W'(GROUP_MAX);
    return r;
  endfunction

endpackage

/* hdl/xpre_parity_store.sv */
// Payload parity memory: rows of bytes with per-row valid bits for group clearing.
module xpre_parity_store import xpre_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ROW_AW-1:0]   rd_row,
  output logic [ROW_BITS-1:0] rd_data,
  input  xpre_wr_t            wr,
  input  logic                clear,
  input  logic [ROW_AW-1:0]   chk_row,
  output logic                chk_valid
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     row_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

  // A row that is not valid is taken as zero by the top level, so clearing the bits empties the store.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.row] <= 1'b1;
    end
  end

  assign chk_valid = row_valid[chk_row];

endmodule

/* hdl/xor_parity_repair_encoder_unit.sv */
// Top level of the XOR parity repair encoder for RTP packet groups.
// Result path: an accepted request is held in stage s1, and its result in the output register.
// Throughput: one request per cycle while the output is not stalled, set by the single
// read-modify-write of the parity row memory (read at accept, write as s1 fires, forwarded).
// Reset: group size 4, packet count cleared, header set to its initial value,
// all parity rows marked empty; requests are taken right after reset.
module xor_parity_repair_encoder_unit import xpre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // From bit 0: pad_bit, ext_bit, csrc_count, marker_bit, payload_type, timestamp,
  // seq_number, ssrc, payload_length, byte_index, data_byte, zero fill.
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  // func
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // repair_byte
  output logic [7:0]            m_axis_tdata,
  // group_complete
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  item_t             in_item;
  func_t             in_func;
  logic              acc;
  logic [CNT_W-1:0]  group_size;
  logic [CNT_W-1:0]  grp;
  logic [IDX_W-1:0]  seq_end;
  logic [IDX_W-1:0]  rd_off;
  logic [PAY_AW-1:0] in_paddr;
  logic              in_pay_ok;

  logic                s1_valid;
  func_t               s1_func;
  item_t               s1_item;
  logic [PAY_AW-1:0]   s1_paddr;
  logic                s1_pay_ok;
  logic                s1_fwd_hit;
  logic [ROW_BITS-1:0] s1_fwd_data;

  logic                has_result;
  logic                fire;
  logic [ROW_AW-1:0]   s1_row;
  logic [LANE_AW-1:0]  s1_lane;
  logic                row_ok;
  logic [ROW_BITS-1:0] rd_data;
  logic [ROW_BITS-1:0] row_cur;
  logic [ROW_BITS-1:0] row_new;
  logic [7:0]          lane_cur;
  xpre_wr_t            wr;
  logic                clear;

  logic [CNT_W-1:0]  packet_count;
  logic [CNT_W-1:0]  cnt_inc;
  logic              done;
  logic [63:0]       recovery_header;
  logic [63:0]       hdr_base;
  logic [31:0]       first_ssrc;
  logic [15:0]       seq_list [GROUP_MAX];

  logic [IDX_W-1:0]  rel;
  logic [IDX_W-1:0]  hrel;
  logic [GRP_AW-1:0] entry;
  logic [15:0]       seq_sel;
  logic [7:0]        body;

  logic              m_valid;
  logic [7:0]        m_byte;
  logic              m_last;

  assign in_item = item_t'(s_axis_tdata);
  assign in_func = func_t'(s_axis_tuser);
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign grp     = eff_group(group_size);
  assign seq_end = IDX_W'(BODY_FIXED) + IDX_W'({grp, 2'b00});
  assign rd_off  = in_item.byte_index - seq_end;

  // Payload address is worked out at accept so the row read can start at once.
  always_comb begin
    in_paddr  = in_item.byte_index[PAY_AW-1:0];
    in_pay_ok = 1'b0;
    case (in_func)
      FUNC_PAYLOAD: begin
        in_pay_ok = {1'b0, in_item.byte_index} < (IDX_W+1)'(PAYLOAD_MAX);
      end
      FUNC_READ: begin
        in_paddr  = rd_off[PAY_AW-1:0];
        in_pay_ok = (in_item.byte_index >= seq_end) &&
                    ({1'b0, rd_off} < (IDX_W+1)'(PAYLOAD_MAX));
      end
      default: begin
        in_pay_ok = 1'b0;
      end
    endcase
  end

  assign has_result    = (s1_func == FUNC_EOP) || (s1_func == FUNC_READ);
  assign fire          = s1_valid && (!has_result || !m_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || fire;
  assign cfg_ready     = 1'b1;

  assign s1_row   = s1_paddr[PAY_AW-1:LANE_AW];
  assign s1_lane  = s1_paddr[LANE_AW-1:0];
  assign row_cur  = !row_ok ? '0 : (s1_fwd_hit ? s1_fwd_data : rd_data);
  assign lane_cur = row_cur[{s1_lane, 3'b000} +: 8];
  assign row_new  = row_cur ^ (ROW_BITS'(s1_item.data_byte) << {s1_lane, 3'b000});

  assign wr.en   = fire && (s1_func == FUNC_PAYLOAD) && s1_pay_ok;
  assign wr.row  = s1_row;
  assign wr.data = row_new;
  assign clear   = fire && (s1_func == FUNC_HEADER) && (packet_count == '0);

  xpre_parity_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (acc),
    .rd_row    (in_paddr[PAY_AW-1:LANE_AW]),
    .rd_data   (rd_data),
    .wr        (wr),
    .clear     (clear),
    .chk_row   (s1_row),
    .chk_valid (row_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // A write in the accept cycle to the same row is missed by the memory read.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_func     <= in_func;
      s1_item     <= in_item;
      s1_paddr    <= in_paddr;
      s1_pay_ok   <= in_pay_ok;
      s1_fwd_hit  <= wr.en && (wr.row == in_paddr[PAY_AW-1:LANE_AW]);
      s1_fwd_data <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      group_size <= cfg_data;
    end
  end

  assign cnt_inc  = packet_count + CNT_W'(1);
  assign done     = cnt_inc >= grp;
  assign hdr_base = (packet_count == '0) ? HDR_INIT : recovery_header;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_count    <= '0;
      recovery_header <= HDR_INIT;
      first_ssrc      <= '0;
      for (int i = 0; i < GROUP_MAX; i++) begin
        seq_list[i] <= '0;
      end
    end else if (fire) begin
      if (s1_func == FUNC_HEADER) begin
        if (packet_count == '0) begin
          first_ssrc <= s1_item.ssrc;
        end
        recovery_header <= hdr_base ^ {2'b00, s1_item.pad_bit, s1_item.ext_bit,
                                       s1_item.csrc_count, s1_item.marker_bit,
                                       s1_item.payload_type, 4'b0000,
                                       s1_item.payload_length, s1_item.timestamp};
        if (int'(packet_count) < GROUP_MAX) begin
          seq_list[packet_count[GRP_AW-1:0]] <= s1_item.seq_number;
        end
      end else if (s1_func == FUNC_EOP) begin
        packet_count <= done ? '0 : cnt_inc;
      end
    end
  end

  // Repair body: SSRC, recovery header, sequence entries, payload parity.
  assign rel     = s1_item.byte_index - IDX_W'(BODY_FIXED);
  assign hrel    = s1_item.byte_index - IDX_W'(4);
  assign entry   = rel[GRP_AW+1:2];
  assign seq_sel = seq_list[entry];

  always_comb begin
    body = '0;
    if (s1_item.byte_index < IDX_W'(4)) begin
      body = first_ssrc[{~s1_item.byte_index[1:0], 3'b000} +: 8];
    end else if (s1_item.byte_index < IDX_W'(BODY_FIXED)) begin
      body = recovery_header[{~hrel[2:0], 3'b000} +: 8];
    end else if (s1_item.byte_index < seq_end) begin
      case (rel[1:0])
        2'd0:    body = seq_sel[15:8];
        2'd1:    body = seq_sel[7:0];
        2'd2:    body = 8'(grp);
        default: body = '0;
      endcase
    end else if (s1_pay_ok) begin
      body = lane_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (fire && has_result) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      m_byte <= (s1_func == FUNC_READ) ? body : '0;
      m_last <= (s1_func == FUNC_EOP) && done;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_byte;
  assign m_axis_tlast  = m_last;

endmodule

/* hdl/xpre_port_checker.sv */
// Port-level checks of the XOR parity repair encoder, bound to the top level.
`include "xor_parity_repair_encoder_unit_assert.svh"

module xpre_port_checker import xpre_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [7:0]            m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic out_wait;

  assign out_wait = m_axis_tvalid && !m_axis_tready;

  // A stalled result keeps its contents.
  `XPRE_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))

  // A group completion carries no repair byte.
  `XPRE_ASSERT_IMP(a_done_no_byte, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 8'd0)

  // A fresh result follows an earlier accepted request.
  `XPRE_ASSERT_IMP(a_out_cause, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

  // Nothing is offered right after reset.
  `XPRE_ASSERT_ALW(a_reset_quiet, $past(rst), !m_axis_tvalid)

endmodule

bind xor_parity_repair_encoder_unit xpre_port_checker u_port_checker (.*);
